@@ src/iupl_pkg.sv @@
// ----------------------------------------------------------------------------
// iupl_pkg
// Shared types, codes and helpers for the image upload session controller.
// ----------------------------------------------------------------------------
package iupl_pkg;

  localparam int unsigned HDR_BYTES = 4;
  localparam int unsigned IN_W      = 408;
  localparam int unsigned OUT_W     = 136;

  // Command codes carried on the input tuser.
  typedef enum logic [2:0] {
    ACT_INFO   = 3'd0,
    ACT_BEGIN  = 3'd1,
    ACT_DATA   = 3'd2,
    ACT_END    = 3'd3,
    ACT_REVERT = 3'd4,
    ACT_TICK   = 3'd5
  } action_t;

  // Status codes carried on the output tuser.
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_ARG    = 3'd1,
    ST_NOSPC  = 3'd2,
    ST_STATE  = 3'd3,
    ST_OFFSET = 3'd4,
    ST_VERIFY = 3'd5
  } status_t;

  // Session phases.
  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_ACTIVE    = 2'd1,
    PH_SUSPENDED = 2'd2,
    PH_VERIFIED  = 2'd3
  } phase_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_GRANULE  = 2'd0,
    REG_CAPACITY = 2'd1,
    REG_TIMEOUT  = 2'd2,
    REG_CHUNK    = 2'd3
  } reg_idx_t;

  // Request to the shared remainder unit.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } rem_req_t;

  // Answer from the shared remainder unit.
  typedef struct packed {
    logic        done;
    logic [31:0] rem;
  } rem_rsp_t;

  // Round v up to a multiple of g, given r = v mod g; saturates at the top.
  function automatic logic [31:0] round_up(input logic [31:0] v, input logic [31:0] g,
                                           input logic [31:0] r);
    logic [31:0] gap;
    gap = g - r;
    if (g <= 32'd1 || r == 32'd0) begin
      return v;
    end else if (v > (32'hFFFF_FFFF - gap)) begin
      return 32'hFFFF_FFFF;
    end else begin
      return v + gap;
    end
  endfunction

endpackage

@@ src/iupl_rem.sv @@
// ----------------------------------------------------------------------------
// iupl_rem
// Iterative restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module iupl_rem (
  input  logic               clk,
  input  logic               rst_n,
  input  iupl_pkg::rem_req_t req,
  output iupl_pkg::rem_rsp_t rsp
);
  import iupl_pkg::*;

  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] div_r, div_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] shifted;
  logic [32:0] trial;

  // One shift and trial subtract per step.
  always_comb begin
    shifted  = {rem_r, quo_r[31]};
    trial    = shifted - {1'b0, div_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      div_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = trial[32] ? shifted[31:0] : trial[31:0];
      quo_nxt = {quo_r[30:0], 1'b0};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

@@ src/image_upload_session_control.sv @@
// ----------------------------------------------------------------------------
// image_upload_session_control
// Resumable upload session sequencer with progressive erase ahead of the
// write frontier.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Content
// in_     | slave     | tvalid/tready      | one command request
// out_    | master    | tvalid/tready      | one response per request
// cfg_    | slave     | valid/ready        | register index and data
//
// A command without an erase passes through S_EXEC and S_OUT before response
// valid rises. A command that erases runs two 32-step remainders on the shared
// unit before response valid rises. The input is not ready while a command is
// in work or a response waits. Reset is synchronous, clears the session and
// loads the configuration defaults. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module image_upload_session_control (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // image_size, chunk_offset, data_length, length_ok, digest_word0..3,
  // now_time, check_ok, zero pad
  input  logic [407:0] in_tdata,
  // action
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // frontier, image_total, resumed, erase_request, erase_start, erase_length,
  // write_request, write_flush, session_state, zero pad
  output logic [135:0] out_tdata,
  // status
  output logic [2:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import iupl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_LIM, S_TGT, S_RND, S_EMIT, S_OUT
  } seq_t;

  seq_t         seq_r;
  rem_req_t     rq;
  rem_rsp_t     rs;

  // Configuration registers.
  logic [31:0]  granule_r, capacity_r, timeout_r;
  logic [15:0]  chunk_r;

  // Session state.
  phase_t       phase_r, phase_nxt;
  logic [31:0]  total_r, total_nxt;
  logic [63:0]  dig_r [4];
  logic [63:0]  dig_nxt [4];
  logic [31:0]  front_r, front_nxt;
  logic [31:0]  erased_r;
  logic [63:0]  last_r, last_nxt;

  // Latched request.
  logic [2:0]   act_r;
  logic [31:0]  size_r, off_r;
  logic [15:0]  dlen_r;
  logic         lok_r, chk_r;
  logic [63:0]  idig_r [4];
  logic [63:0]  now_r;

  // Execution results.
  status_t      st_nxt, st_r;
  logic         res_nxt, res_r, wr_nxt, wr_r, fl_nxt, fl_r;
  logic         doer_nxt;
  logic [31:0]  need_nxt, need_r;
  logic         er_r;
  logic [31:0]  ers_r, erl_r;
  logic [31:0]  lim_r, tgt0_r, tgt_r;
  logic [31:0]  lim_ru;
  logic [32:0]  end_pos;
  logic         out_valid_r;
  logic         match;

  iupl_rem u_rem (.clk(clk), .rst_n(rst_n), .req(rq), .rsp(rs));

  assign in_tready = (seq_r == S_IDLE) && !out_valid_r;
  assign cfg_ready = 1'b1;
  assign end_pos   = {1'b0, off_r} + {17'd0, dlen_r};
  assign match     = (dig_r[0] == idig_r[0]) && (dig_r[1] == idig_r[1]) &&
                     (dig_r[2] == idig_r[2]) && (dig_r[3] == idig_r[3]);
  assign lim_ru    = round_up(total_r, granule_r, rs.rem);

  // Command decode and session update.
  always_comb begin
    st_nxt    = ST_OK;
    res_nxt   = 1'b0;
    wr_nxt    = 1'b0;
    fl_nxt    = 1'b0;
    doer_nxt  = 1'b0;
    need_nxt  = '0;
    phase_nxt = phase_r;
    total_nxt = total_r;
    front_nxt = front_r;
    last_nxt  = last_r;
    for (int i = 0; i < 4; i++) dig_nxt[i] = dig_r[i];
    unique case (act_r)
      ACT_INFO: begin
        if (!lok_r) st_nxt = ST_ARG;
      end
      ACT_BEGIN: begin
        if (!lok_r || size_r == 32'd0) begin
          st_nxt = ST_ARG;
        end else if (capacity_r == 32'd0 || size_r > capacity_r) begin
          st_nxt = ST_NOSPC;
        end else begin
          res_nxt = (phase_r == PH_ACTIVE || phase_r == PH_SUSPENDED) &&
                    total_r == size_r && match;
          if (!res_nxt) begin
            total_nxt = size_r;
            front_nxt = '0;
            for (int i = 0; i < 4; i++) dig_nxt[i] = idig_r[i];
            doer_nxt  = 1'b1;
          end
          phase_nxt = PH_ACTIVE;
          last_nxt  = now_r;
        end
      end
      ACT_DATA: begin
        if (phase_r != PH_ACTIVE) begin
          st_nxt = ST_STATE;
        end else if (dlen_r == 16'd0 || dlen_r > chunk_r || off_r > total_r ||
                     {16'd0, dlen_r} > (total_r - off_r)) begin
          st_nxt = ST_ARG;
        end else if (off_r != front_r) begin
          if (off_r < front_r && end_pos[31:0] <= front_r) last_nxt = now_r;
          else st_nxt = ST_OFFSET;
        end else begin
          doer_nxt  = 1'b1;
          need_nxt  = end_pos[31:0];
          wr_nxt    = 1'b1;
          fl_nxt    = end_pos[31:0] == total_r;
          front_nxt = end_pos[31:0];
          last_nxt  = now_r;
        end
      end
      ACT_END: begin
        if (!lok_r) begin
          st_nxt = ST_ARG;
        end else if (phase_r != PH_ACTIVE && phase_r != PH_VERIFIED) begin
          st_nxt = ST_STATE;
        end else if (front_r != total_r) begin
          st_nxt = ST_STATE;
        end else if (total_r < HDR_BYTES || !chk_r) begin
          st_nxt    = ST_VERIFY;
          phase_nxt = PH_IDLE;
          total_nxt = '0;
          front_nxt = '0;
          last_nxt  = '0;
          for (int i = 0; i < 4; i++) dig_nxt[i] = '0;
        end else begin
          phase_nxt = PH_VERIFIED;
        end
      end
      ACT_TICK: begin
        if (phase_r == PH_ACTIVE && (now_r - last_r) >= {32'd0, timeout_r})
          phase_nxt = PH_SUSPENDED;
      end
      default: begin
        phase_nxt = PH_IDLE;
        total_nxt = '0;
        front_nxt = '0;
        last_nxt  = '0;
        for (int i = 0; i < 4; i++) dig_nxt[i] = '0;
      end
    endcase
  end

  // Remainder requests: the image size first, then the erase target.
  always_comb begin
    rq.start    = 1'b0;
    rq.dividend = total_r;
    rq.divisor  = granule_r;
    if (seq_r == S_EXEC && doer_nxt) begin
      rq.start    = 1'b1;
      rq.dividend = total_nxt;
    end else if (seq_r == S_TGT) begin
      rq.start    = 1'b1;
      rq.dividend = tgt0_r;
    end
  end

  // Sequencer, session registers and response registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= S_IDLE;
      out_valid_r <= 1'b0;
      granule_r   <= 32'd4096;
      capacity_r  <= 32'd1048576;
      timeout_r   <= 32'd5000;
      chunk_r     <= 16'd512;
      phase_r     <= PH_IDLE;
      total_r     <= '0;
      front_r     <= '0;
      erased_r    <= '0;
      last_r      <= '0;
      for (int i = 0; i < 4; i++) dig_r[i] <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (reg_idx_t'(cfg_index))
          REG_GRANULE:  granule_r  <= cfg_data;
          REG_CAPACITY: capacity_r <= cfg_data;
          REG_TIMEOUT:  timeout_r  <= cfg_data;
          REG_CHUNK:    chunk_r    <= cfg_data[15:0];
        endcase
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (seq_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            act_r   <= in_tuser;
            size_r  <= in_tdata[31:0];
            off_r   <= in_tdata[63:32];
            dlen_r  <= in_tdata[79:64];
            lok_r   <= in_tdata[80];
            idig_r[0] <= in_tdata[144:81];
            idig_r[1] <= in_tdata[208:145];
            idig_r[2] <= in_tdata[272:209];
            idig_r[3] <= in_tdata[336:273];
            now_r   <= in_tdata[400:337];
            chk_r   <= in_tdata[401];
            seq_r   <= S_EXEC;
          end
        end
        S_EXEC: begin
          phase_r <= phase_nxt;
          total_r <= total_nxt;
          front_r <= front_nxt;
          last_r  <= last_nxt;
          for (int i = 0; i < 4; i++) dig_r[i] <= dig_nxt[i];
          if (phase_nxt == PH_IDLE || (act_r == ACT_BEGIN && doer_nxt)) begin
            erased_r <= '0;
          end
          st_r   <= st_nxt;
          res_r  <= res_nxt;
          wr_r   <= wr_nxt;
          fl_r   <= fl_nxt;
          need_r <= need_nxt;
          er_r   <= 1'b0;
          ers_r  <= '0;
          erl_r  <= '0;
          seq_r  <= doer_nxt ? S_LIM : S_OUT;
        end
        S_LIM: begin
          if (rs.done) begin
            lim_r  <= (lim_ru > capacity_r) ? capacity_r : lim_ru;
            tgt0_r <= (need_r > (32'hFFFF_FFFF - granule_r)) ?
                      ((lim_ru > capacity_r) ? capacity_r : lim_ru) :
                      need_r + granule_r;
            seq_r  <= S_TGT;
          end
        end
        S_TGT: begin
          seq_r <= S_RND;
        end
        S_RND: begin
          if (rs.done) begin
            tgt_r <= round_up(tgt0_r, granule_r, rs.rem);
            seq_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Clamp to the limit, never below the needed end.
          if (((tgt_r > lim_r) ? ((lim_r < need_r) ? need_r : lim_r) :
               ((tgt_r < need_r) ? need_r : tgt_r)) > erased_r) begin
            er_r     <= 1'b1;
            ers_r    <= erased_r;
            erl_r    <= ((tgt_r > lim_r) ? ((lim_r < need_r) ? need_r : lim_r) :
                         ((tgt_r < need_r) ? need_r : tgt_r)) - erased_r;
            erased_r <= (tgt_r > lim_r) ? ((lim_r < need_r) ? need_r : lim_r) :
                        ((tgt_r < need_r) ? need_r : tgt_r);
          end
          seq_r <= S_OUT;
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          seq_r       <= S_IDLE;
        end
        default: seq_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = st_r;
  assign out_tdata  = {2'b00, phase_r, fl_r, wr_r, erl_r, ers_r, er_r, res_r,
                       total_r, front_r};

`ifndef SYNTHESIS
  // A flush only comes with a write.
  a_flush_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[131] |-> out_tdata[130])
    else $error("flush without write request");

  // An issued erase range is never empty.
  a_erase_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[65] |-> out_tdata[129:98] != 32'd0)
    else $error("empty erase range");

  // A resumed session answers ok and is active.
  a_resume: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[64] |-> out_tuser == ST_OK && out_tdata[133:132] == PH_ACTIVE)
    else $error("resume with bad status or phase");

  // A response never waits while a new request is taken.
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid && seq_r == S_IDLE)
    else $error("request taken while busy");
`endif

endmodule
